// ----- rtl/c_source_token_splitter_macros.svh -----
// Assertion macros used by the token splitter checker.
`ifndef C_SOURCE_TOKEN_SPLITTER_MACROS_SVH
`define C_SOURCE_TOKEN_SPLITTER_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define CSTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked during reset.
`define CSTS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/csts_pkg.sv -----
// Shared types and constants of the C source token splitter.
package csts_pkg;

	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 16;
	localparam int QUEUE_DEPTH = 4;
	// results one source byte can cause at most
	localparam int SLOTS       = 3;

	typedef logic [LINE_BITS-1:0]   line_t;
	typedef logic [COLUMN_BITS-1:0] col_t;

	typedef enum logic [2:0] {
		KIND_WS    = 3'd0,
		KIND_NL    = 3'd1,
		KIND_STR   = 3'd2,
		KIND_ID    = 3'd3,
		KIND_PUNCT = 3'd4,
		KIND_EOF   = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] char_value;
		logic       final_byte;
	} byte_t;

	typedef struct packed {
		logic [7:0] out_char;
		kind_t      token_kind;
		logic       token_start;
		line_t      line_number;
		col_t       column_number;
		logic       space_before;
		logic       run_end;
	} tok_t;

	// all results of one byte; mask marks the slots in use
	typedef struct packed {
		tok_t [SLOTS-1:0] slot;
		logic [SLOTS-1:0] mask;
	} entry_t;

endpackage

// ----- rtl/csts_front.sv -----
// Front end: lexer state machine that turns each byte into at most one request of results.
module csts_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_ready,
	input  csts_pkg::byte_t byte_data,
	input  logic            queue_full,
	output logic            push,
	output csts_pkg::entry_t push_entry
);
	import csts_pkg::*;

	typedef enum logic [7:0] {
		M_NORMAL     = 8'b0000_0001,
		M_IDENT      = 8'b0000_0010,
		M_STRING     = 8'b0000_0100,
		M_STR_ESC    = 8'b0000_1000,
		M_SLASH      = 8'b0001_0000,
		M_LINE_CMT   = 8'b0010_0000,
		M_BLOCK      = 8'b0100_0000,
		M_BLOCK_STAR = 8'b1000_0000
	} mode_t;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_DQ    = 8'd34;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_BSL   = 8'd92;
	localparam logic [7:0] CH_UNDER = 8'd95;
	localparam logic [7:0] CH_NUL   = 8'd0;

	localparam int SLOT_SLASH = 0;
	localparam int SLOT_MAIN  = 1;
	localparam int SLOT_EOF   = 2;

	localparam line_t LINE_ONE = line_t'(1);
	localparam col_t  COL_ONE  = col_t'(1);

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		return is_alpha(c) || (c >= 8'd48 && c <= 8'd57) || (c == CH_UNDER);
	endfunction

	function automatic line_t line_inc(line_t v);
		return (v == '1) ? v : v + LINE_ONE;
	endfunction

	function automatic col_t col_inc(col_t v);
		return (v == '1) ? v : v + COL_ONE;
	endfunction

	function automatic tok_t mk(logic [7:0] c, kind_t k, logic st, line_t l, col_t col,
		logic sb);
		tok_t t;
		t.out_char      = c;
		t.token_kind    = k;
		t.token_start   = st;
		t.line_number   = l;
		t.column_number = col;
		t.space_before  = sb;
		t.run_end       = 1'b0;
		return t;
	endfunction

	mode_t mode_q, mode_d;
	line_t line_q, line_d, tline_q, tline_d;
	col_t  col_q, col_d, tcol_q, tcol_d;
	logic  pws_q, pws_d, tspace_q, tspace_d;
	logic  do_norm, accept;
	logic [7:0] c;
	logic  fin;
	kind_t kind;
	entry_t ent;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;
	assign c          = byte_data.char_value;
	assign fin        = byte_data.final_byte;

	// next state and results of one byte
	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		col_d    = col_q;
		pws_d    = pws_q;
		tline_d  = tline_q;
		tcol_d   = tcol_q;
		tspace_d = tspace_q;
		do_norm  = 1'b0;
		kind     = KIND_PUNCT;
		ent      = '0;

		unique case (mode_q)
			M_IDENT: begin
				if (is_ident(c)) begin
					ent.slot[SLOT_MAIN] = mk(c, KIND_ID, 1'b0, tline_q, tcol_q, tspace_q);
					ent.mask[SLOT_MAIN] = 1'b1;
					col_d = col_inc(col_q);
				end else begin
					do_norm = 1'b1;
				end
			end
			M_STRING, M_STR_ESC: begin
				ent.slot[SLOT_MAIN] = mk(c, KIND_STR, 1'b0, tline_q, tcol_q, tspace_q);
				ent.mask[SLOT_MAIN] = 1'b1;
				col_d = col_inc(col_q);
				if (mode_q == M_STR_ESC) begin
					mode_d = M_STRING;
				end else if (c == CH_BSL) begin
					mode_d = M_STR_ESC;
				end else if (c == CH_DQ) begin
					mode_d = M_NORMAL;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH || c == CH_STAR) begin
					// comment opens: one space token at the slash position
					ent.slot[SLOT_MAIN] = mk(CH_SPACE, KIND_WS, 1'b1, tline_q, tcol_q, 1'b1);
					ent.mask[SLOT_MAIN] = 1'b1;
					pws_d  = 1'b1;
					col_d  = col_inc(col_q);
					mode_d = (c == CH_SLASH) ? M_LINE_CMT : M_BLOCK;
				end else begin
					// held slash was a plain punctuator
					ent.slot[SLOT_SLASH] = mk(CH_SLASH, KIND_PUNCT, 1'b1, tline_q, tcol_q,
						tspace_q);
					ent.mask[SLOT_SLASH] = 1'b1;
					pws_d   = 1'b0;
					do_norm = 1'b1;
				end
			end
			M_LINE_CMT: begin
				if (c == CH_NL) begin
					do_norm = 1'b1;
				end else begin
					col_d = col_inc(col_q);
				end
			end
			M_BLOCK, M_BLOCK_STAR: begin
				if (mode_q == M_BLOCK_STAR && c == CH_SLASH) begin
					mode_d = M_NORMAL;
				end else if (c == CH_STAR) begin
					mode_d = M_BLOCK_STAR;
				end else begin
					mode_d = M_BLOCK;
				end
				if (c == CH_NL) begin
					line_d = line_inc(line_q);
				end
				col_d = col_inc(col_q);
			end
			default: begin
				do_norm = 1'b1;
			end
		endcase

		// byte handled from the normal mode
		if (do_norm) begin
			if (is_ws(c)) begin
				ent.slot[SLOT_MAIN] = mk(c, (c == CH_NL) ? KIND_NL : KIND_WS, 1'b1,
					line_d, col_d, 1'b1);
				ent.mask[SLOT_MAIN] = 1'b1;
				pws_d = 1'b1;
				if (c == CH_NL) begin
					line_d = line_inc(line_d);
					col_d  = COL_ONE;
				end else begin
					col_d = col_inc(col_d);
				end
				mode_d = M_NORMAL;
			end else if (c == CH_SLASH && !fin) begin
				tline_d  = line_d;
				tcol_d   = col_d;
				tspace_d = pws_d;
				col_d    = col_inc(col_d);
				mode_d   = M_SLASH;
			end else begin
				mode_d = M_NORMAL;
				if (c == CH_DQ) begin
					kind   = KIND_STR;
					mode_d = M_STRING;
				end else if (is_alpha(c) || c == CH_UNDER) begin
					kind   = KIND_ID;
					mode_d = M_IDENT;
				end
				tline_d  = line_d;
				tcol_d   = col_d;
				tspace_d = pws_d;
				ent.slot[SLOT_MAIN] = mk(c, kind, 1'b1, line_d, col_d, pws_d);
				ent.mask[SLOT_MAIN] = 1'b1;
				pws_d = 1'b0;
				col_d = col_inc(col_d);
			end
		end

		// end of source: report and start over
		if (fin) begin
			ent.slot[SLOT_EOF] = mk(CH_NUL, KIND_EOF, 1'b1, line_d, col_d, pws_d);
			ent.mask[SLOT_EOF] = 1'b1;
			mode_d   = M_NORMAL;
			line_d   = LINE_ONE;
			col_d    = COL_ONE;
			pws_d    = 1'b0;
			tline_d  = LINE_ONE;
			tcol_d   = COL_ONE;
			tspace_d = 1'b0;
		end
	end

	assign push       = accept && (ent.mask != '0);
	assign push_entry = ent;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_NORMAL;
			line_q   <= LINE_ONE;
			col_q    <= COL_ONE;
			pws_q    <= 1'b0;
			tline_q  <= LINE_ONE;
			tcol_q   <= COL_ONE;
			tspace_q <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			line_q   <= line_d;
			col_q    <= col_d;
			pws_q    <= pws_d;
			tline_q  <= tline_d;
			tcol_q   <= tcol_d;
			tspace_q <= tspace_d;
		end
	end

endmodule

// ----- rtl/csts_queue.sv -----
// Short queue of result requests between the lexer and the output serializer.
module csts_queue #(
	parameter int DEPTH = csts_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  csts_pkg::entry_t push_entry,
	output logic             full,
	output logic             head_valid,
	output csts_pkg::entry_t head_entry,
	input  logic             pop
);
	import csts_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/csts_back.sv -----
// Back end: sends queued results one per cycle, unless stalled, through an output register.
module csts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  csts_pkg::entry_t head_entry,
	output logic             pop,
	output logic             tok_valid,
	input  logic             tok_ready,
	output csts_pkg::tok_t   tok_data
);
	import csts_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] done_q, pending, sel_oh;
	logic [IW-1:0]    idx;
	logic             last, load, valid_q;
	tok_t             data_q, next_tok;

	// lowest slot still to send
	always_comb begin
		pending = head_entry.mask & ~done_q;
		sel_oh  = pending & ~(pending - SLOTS'(1));
		idx     = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				idx = IW'(i);
			end
		end
		last             = ((pending & ~sel_oh) == '0);
		next_tok         = head_entry.slot[idx];
		next_tok.run_end = last;
	end

	assign load = head_valid && (!valid_q || tok_ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				done_q  <= last ? '0 : (done_q | sel_oh);
			end else if (tok_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= next_tok;
		end
	end

	assign tok_valid = valid_q;
	assign tok_data  = data_q;

endmodule

// ----- rtl/c_source_token_splitter.sv -----
// C source token splitter: tags each source byte with its token kind, line and column.
//
// One source byte is taken per cycle while the result queue has room; the lexer state
// update is a loop within the front end, so bytes may follow back to back. A byte
// causes zero to three results (a held slash, the byte's own token, end of file), and the
// output register sends one result per cycle while the output is not stalled. Bytes
// inside a comment cause no result; the opening pair gives one space token. A result
// passes through the queue storage and then the output register. DEPTH sets how many
// bytes' results the queue between lexer and output can hold.
module c_source_token_splitter #(
	parameter int DEPTH = csts_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_ready,
	input  csts_pkg::byte_t byte_data,
	output logic            tok_valid,
	input  logic            tok_ready,
	output csts_pkg::tok_t  tok_data
);
	import csts_pkg::*;

	logic   q_full, q_push, q_head_valid, q_pop;
	entry_t q_push_entry, q_head_entry;

	csts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.queue_full (q_full),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	csts_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry),
		.pop        (q_pop)
	);

	csts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry),
		.pop        (q_pop),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_data   (tok_data)
	);

endmodule

// ----- rtl/csts_checker.sv -----
// Port-level checker of the token splitter and its bind to the top level.
`include "c_source_token_splitter_macros.svh"

module csts_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            byte_valid,
	input logic            byte_ready,
	input csts_pkg::byte_t byte_data,
	input logic            tok_valid,
	input logic            tok_ready,
	input csts_pkg::tok_t  tok_data
);
	import csts_pkg::*;

	// a stalled result stays put
	`CSTS_ASSERT(a_tok_hold,
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_data),
		"result changed while stalled")

	// end of file is always the last result of its byte
	`CSTS_ASSERT(a_eof_last,
		tok_valid && tok_data.token_kind == KIND_EOF |-> tok_data.run_end,
		"end of file not last of its run")

	// whitespace tokens carry the whitespace-before flag
	`CSTS_ASSERT(a_ws_space,
		tok_valid && tok_data.token_kind == KIND_WS |-> tok_data.space_before,
		"whitespace token without space flag")

	// positions count from one
	`CSTS_ASSERT(a_pos_nonzero,
		tok_valid |-> tok_data.line_number != '0 && tok_data.column_number != '0,
		"zero line or column")

	// nothing is offered once a reset edge has been seen
	`CSTS_ASSERT_RST(a_reset_idle, !arst_n |=> !tok_valid, "result valid after reset")

endmodule

bind c_source_token_splitter csts_checker u_csts_checker (.*);
